// ----- rtl/base64_stream_encoder_assert.svh -----
// ---------------------------------------------------------------------------
// base64 stream encoder assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define B64E_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/b64e_pkg.sv -----
// ---------------------------------------------------------------------------
// b64e_pkg
// types, constants and the character table of the base64 stream encoder
// ---------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned SLOTS = 4;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } b64e_phase_t;

  // characters produced by one input word
  typedef struct packed {
    logic [SLOTS-1:0][5:0] sextet;
    logic [SLOTS-1:0]      pad;
    logic [1:0]            cnt_m1;
    logic                  fin;
  } b64e_job_t;

  function automatic logic [7:0] b64e_char(input logic [5:0] s);
    logic [7:0] c;
    c = 8'h00;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ----- rtl/base64_stream_encoder.sv -----
// ---------------------------------------------------------------------------
// base64_stream_encoder
// byte stream in, base64 ascii characters out, with '=' padding per message
// ---------------------------------------------------------------------------
// channel | dir | tdata          | tlast
// in_     | in  | [7:0] raw byte | last byte of message
// out_    | out | [7:0] ascii    | last char of message
//
// one word accepted per cycle while the two-entry job queue has room
// one char per cycle out of the back part while out_tready allows; a byte
// costs 1 to 4 chars, 4 chars per 3 bytes in steady state
// first char goes via the job queue, current job and output registers
// rst_n synchronous, clears group position, leftover bits, queue and output
// input and output stall independently through the queue and output register
module base64_stream_encoder import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_code
  output logic       out_tlast
);

  b64e_job_t front_job, q_job;
  logic      q_full, q_valid, pop, acc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_tdata),
    .final_byte (in_tlast),
    .job        (front_job)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .push_job (front_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/b64e_front.sv -----
// ---------------------------------------------------------------------------
// b64e_front
// accepts bytes, tracks group position and leftover bits, builds char jobs
// ---------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output b64e_job_t  job
);

  b64e_phase_t phase_r, phase_nxt;
  logic [3:0]  res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      res_r   <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      res_r   <= res_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    res_nxt   = res_r;
    if (acc) begin
      case (phase_r)
        PH_1: begin
          phase_nxt = PH_2;
          res_nxt   = data_byte[3:0];
        end
        PH_2: begin
          phase_nxt = PH_0;
          res_nxt   = 4'd0;
        end
        default: begin
          phase_nxt = PH_1;
          res_nxt   = {2'b00, data_byte[1:0]};
        end
      endcase
      if (final_byte) begin
        phase_nxt = PH_0;
        res_nxt   = 4'd0;
      end
    end
  end

  // outputs
  always_comb begin
    job        = '0;
    job.fin    = final_byte;
    case (phase_r)
      PH_1: begin
        job.sextet[0] = {res_r[1:0], data_byte[7:4]};
        if (final_byte) begin
          job.sextet[1] = {data_byte[3:0], 2'b00};
          job.pad[2]    = 1'b1;
          job.cnt_m1    = 2'd2;
        end
      end
      PH_2: begin
        job.sextet[0] = {res_r, data_byte[7:6]};
        job.sextet[1] = data_byte[5:0];
        job.cnt_m1    = 2'd1;
      end
      default: begin
        job.sextet[0] = data_byte[7:2];
        if (final_byte) begin
          job.sextet[1] = {data_byte[1:0], 4'b0000};
          job.pad[2]    = 1'b1;
          job.pad[3]    = 1'b1;
          job.cnt_m1    = 2'd3;
        end
      end
    endcase
  end

endmodule

// ----- rtl/b64e_queue.sv -----
// ---------------------------------------------------------------------------
// b64e_queue
// two-entry job queue between the front and back parts
// ---------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64e_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output b64e_job_t q_job
);

  b64e_job_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/b64e_back.sv -----
// ---------------------------------------------------------------------------
// b64e_back
// steps through one job's characters, maps them to ascii, registers output
// ---------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  b64e_job_t  q_job,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  b64e_job_t  cur_r, cur_nxt;
  logic       cur_vld_r, cur_vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic       emit, done, slot_last;

  assign emit      = cur_vld_r && (!out_vld_r || out_tready);
  assign slot_last = (idx_r == cur_r.cnt_m1);
  assign done      = emit && slot_last;
  assign pop       = q_valid && (!cur_vld_r || done);

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (pop) begin
      cur_nxt     = q_job;
      cur_vld_nxt = 1'b1;
      idx_nxt     = 2'd0;
    end else if (done) begin
      cur_vld_nxt = 1'b0;
      idx_nxt     = 2'd0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    if (emit) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = cur_r.pad[idx_r] ? PAD_CHAR : b64e_char(cur_r.sextet[idx_r]);
      out_last_nxt = cur_r.fin && slot_last;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `B64E_ASSERT_SAME(a_idx_in_range, cur_vld_r, idx_r <= cur_r.cnt_m1, "char index past job end")
  `B64E_ASSERT_SAME(a_first_not_pad, cur_vld_r && idx_r == 2'd0, !cur_r.pad[0],
                    "job starts with a pad char")
  `B64E_ASSERT_NEXT(a_last_ends_job, emit && cur_r.fin && slot_last, idx_r == 2'd0,
                    "index not rewound after final char")

endmodule
